### rtl/core/assert_macros.svh
// assertion macros used by the checker file bia_checker.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BIA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

// next-cycle implication, disabled while reset is low
`define BIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`endif

### rtl/core/bia_pkg.sv
// shared types and constants of the bitmap id allocator
// no dependencies
`default_nettype none

package bia_pkg;

    localparam int MAP_W     = 64;
    localparam int ID_W      = 6;
    localparam int CNT_W     = 7;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int DATA_W    = 16;
    localparam int GRP_W     = 8;
    localparam int NGRP      = MAP_W / GRP_W;
    localparam int GRP_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLAIM   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LIVE  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FREE  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SHORT = 3'd4;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_CLAIM,
        OP_RELEASE,
        OP_LIST,
        OP_RESERVE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  ident;
        logic [CNT_W-1:0] want_count;
        logic             in_pool;
    } cmd_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_PICK
    } eng_state_t;

endpackage

`default_nettype wire

### rtl/core/bia_front.sv
// front end: decodes incoming commands and holds them in a two-entry queue
// depends on bia_pkg
`default_nettype none

module bia_front #(
    parameter int CAPACITY = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [bia_pkg::DATA_W-1:0] s_tdata,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output bia_pkg::cmd_item_t             q_item
);
    import bia_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [CMD_W-1:0]  in_cmd;
    logic [ID_W-1:0]   in_ident;
    logic [CNT_W-1:0]  in_want;
    cmd_item_t         dec_item;

    cmd_item_t         q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_ident = s_tdata[CMD_W+ID_W-1:CMD_W];
    assign in_want  = s_tdata[CMD_W+ID_W+CNT_W-1:CMD_W+ID_W];

    // classify the command and flag identifiers outside the pool
    always_comb begin
        dec_item.ident      = in_ident;
        dec_item.want_count = in_want;
        dec_item.in_pool    = ({1'b0, in_ident} < CNT_W'(CAPACITY));
        unique case (in_cmd)
            CMD_ALLOC:   dec_item.op = OP_ALLOC;
            CMD_CLAIM:   dec_item.op = OP_CLAIM;
            CMD_RELEASE: dec_item.op = OP_RELEASE;
            CMD_LIST:    dec_item.op = OP_LIST;
            CMD_RESERVE: dec_item.op = OP_RESERVE;
            default:     dec_item.op = OP_NOP;
        endcase
    end

    assign s_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bia_back.sv
// back end: free bitmap, free count, two-stage lowest-bit search and result register
// depends on bia_pkg
`default_nettype none

module bia_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire bia_pkg::cmd_item_t         q_item,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [bia_pkg::DATA_W-1:0]      m_tdata,
    output logic                            m_tlast
);
    import bia_pkg::*;

    localparam logic [MAP_W-1:0] POOL_MASK = {MAP_W{1'b1}} >> (MAP_W - CAPACITY);

    eng_state_t           state_reg, state_next;
    logic [MAP_W-1:0]     free_map_reg, free_map_next;
    logic [CNT_W-1:0]     free_count_reg, free_count_next;
    logic [MAP_W-1:0]     src_reg, src_next;
    logic                 is_list_reg, is_list_next;
    logic [NGRP-1:0]      grp_any_reg, grp_any_next;
    logic [GRP_IDX_W-1:0] grp_low_reg [NGRP];
    logic [GRP_IDX_W-1:0] grp_low_next [NGRP];

    logic                 m_valid_reg;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [STAT_W-1:0]    out_stat_reg, out_stat_next;
    logic [CNT_W-1:0]     out_total_reg;
    logic                 out_last_reg, out_last_next;
    logic                 load_out;
    logic                 out_free;

    logic                 found;
    logic [ID_W-1:0]      pick_id;
    logic [MAP_W-1:0]     pick_bit;
    logic [MAP_W-1:0]     src_left;
    logic [MAP_W-1:0]     id_bit;
    logic                 id_is_free;

    assign out_free = !m_valid_reg || m_tready;

    // first search stage: per group any-bit and lowest set position
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g] = |src_reg[g*GRP_W +: GRP_W];
            grp_low_next[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--) begin
                if (src_reg[g*GRP_W + b]) begin
                    grp_low_next[g] = GRP_IDX_W'(b);
                end
            end
        end
    end

    // second search stage: lowest group that has a bit
    always_comb begin
        found   = |grp_any_reg;
        pick_id = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                pick_id = {GRP_IDX_W'(g), grp_low_reg[g]};
            end
        end
    end

    assign pick_bit   = MAP_W'(1) << pick_id;
    assign src_left   = src_reg & ~pick_bit;
    assign id_bit     = MAP_W'(1) << q_item.ident;
    assign id_is_free = |(free_map_reg & id_bit);

    always_comb begin
        state_next      = state_reg;
        free_map_next   = free_map_reg;
        free_count_next = free_count_reg;
        src_next        = src_reg;
        is_list_next    = is_list_reg;
        q_ready         = 1'b0;
        load_out        = 1'b0;
        out_id_next     = '0;
        out_stat_next   = STAT_OK;
        out_last_next   = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_item.op)
                        OP_ALLOC: begin
                            q_ready      = 1'b1;
                            src_next     = free_map_reg;
                            is_list_next = 1'b0;
                            state_next   = ST_FIND;
                        end
                        OP_LIST: begin
                            q_ready      = 1'b1;
                            src_next     = ~free_map_reg & POOL_MASK;
                            is_list_next = 1'b1;
                            state_next   = ST_FIND;
                        end
                        OP_CLAIM: begin
                            if (out_free) begin
                                q_ready  = 1'b1;
                                load_out = 1'b1;
                                if (q_item.in_pool && id_is_free) begin
                                    free_map_next   = free_map_reg & ~id_bit;
                                    free_count_next = free_count_reg - CNT_W'(1);
                                end else begin
                                    out_stat_next = STAT_LIVE;
                                end
                            end
                        end
                        OP_RELEASE: begin
                            if (out_free) begin
                                q_ready  = 1'b1;
                                load_out = 1'b1;
                                if (q_item.in_pool && !id_is_free) begin
                                    free_map_next   = free_map_reg | id_bit;
                                    free_count_next = free_count_reg + CNT_W'(1);
                                end else begin
                                    out_stat_next = STAT_FREE;
                                end
                            end
                        end
                        OP_RESERVE: begin
                            if (out_free) begin
                                q_ready       = 1'b1;
                                load_out      = 1'b1;
                                out_stat_next = (free_count_reg >= q_item.want_count) ?
                                                STAT_OK : STAT_SHORT;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                q_ready  = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_FIND: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (!is_list_reg) begin
                        if (found) begin
                            free_map_next   = free_map_reg & ~pick_bit;
                            free_count_next = free_count_reg - CNT_W'(1);
                            out_id_next     = pick_id;
                        end else begin
                            out_stat_next = STAT_FULL;
                        end
                    end else if (found) begin
                        out_id_next   = pick_id;
                        out_last_next = (src_left == '0);
                        src_next      = src_left;
                        if (src_left != '0) begin
                            state_next = ST_FIND;
                        end
                    end else begin
                        // list of an empty pool
                        out_stat_next = STAT_SHORT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_map_reg   <= POOL_MASK;
            free_count_reg <= CNT_W'(CAPACITY);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_map_reg   <= free_map_next;
            free_count_reg <= free_count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_reg     <= src_next;
        is_list_reg <= is_list_next;
        grp_any_reg <= grp_any_next;
        grp_low_reg <= grp_low_next;
        if (load_out) begin
            out_id_reg    <= out_id_next;
            out_stat_reg  <= out_stat_next;
            out_total_reg <= free_count_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_total_reg, out_stat_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/bitmap_id_allocator_top.sv
// top level of the bitmap id allocator: command front end, queue and allocation engine
// depends on bia_pkg, bia_front, bia_back
//
//  channel | dir | tdata fields (low bit up)                        | tlast
//  s_      | in  | cmd[2:0] ident[8:3] want_count[15:9]             | -
//  m_      | out | result_ident[5:0] status[8:6] free_total[15:9]   | last
//
// claim, release, reserve and unused codes: handled in ST_IDLE at the queue head once the result register is free
// allocate: a capture in ST_IDLE, then the registered two-stage lowest-bit search
// list: a capture in ST_IDLE, then ST_FIND and ST_PICK for each live id (once if none is live)
// reset: synchronous, active low; every id free, count equals CAPACITY, no settling time
// the two-entry command queue keeps taking items while the result register waits on m_tready, until it is full
`default_nettype none

module bitmap_id_allocator_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // cmd[2:0], ident[8:3], want_count[15:9]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // result_ident[5:0], status[8:6], free_total[15:9]
    output logic             m_tlast
);
    import bia_pkg::*;

    // decoded command at the queue head
    cmd_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    // decode and buffer commands
    bia_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // bitmap, count, search and result register
    bia_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/bia_checker.sv
// port-level checks of the bitmap id allocator, bound to the top level
// depends on bia_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bia_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);
    import bia_pkg::*;

    logic [ID_W-1:0]   res_id;
    logic [STAT_W-1:0] res_stat;
    logic [CNT_W-1:0]  res_total;
    logic              id_zero;
    logic              full_seen;
    logic              err_seen;

    assign res_id    = m_tdata[ID_W-1:0];
    assign res_stat  = m_tdata[ID_W+STAT_W-1:ID_W];
    assign res_total = m_tdata[ID_W+STAT_W+CNT_W-1:ID_W+STAT_W];
    assign id_zero   = (res_id == '0);
    assign full_seen = m_tvalid && (res_stat == STAT_FULL);
    assign err_seen  = m_tvalid && (res_stat != STAT_OK);

    // a stalled result stays offered
    `BIA_ASSERT_NEXT(a_hold_valid, aclk, aresetn, (m_tvalid && !m_tready), (m_tvalid))
    // full only with nothing free and no id handed out
    `BIA_ASSERT_NOW(a_full_empty, aclk, aresetn, (full_seen), ((res_total == '0) && id_zero))
    // free count never exceeds the pool
    `BIA_ASSERT_NOW(a_total_cap, aclk, aresetn, (m_tvalid), (res_total <= CNT_W'(CAPACITY)))
    // every refusal is a single, final item
    `BIA_ASSERT_NOW(a_err_last, aclk, aresetn, (err_seen), (m_tlast && id_zero))

endmodule

bind bitmap_id_allocator_top bia_checker #(
    .CAPACITY (CAPACITY)
) u_bia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### bench/bia_result_checker.sv
`timescale 1ns / 1ps
// result checker for the bitmap id allocator: keeps its own copy of the pool,
// predicts every result item of each accepted command and compares field by field
// depends on bia_pkg; only watches the command and result channels

module bia_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[2:0], ident[8:3], want_count[15:9]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // result_ident[5:0], status[8:6], free_total[15:9]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import bia_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  free_total;
        logic              last;
    } id_result_t;

    logic [MAP_W-1:0] free_bits;
    logic [CNT_W-1:0] free_num;
    id_result_t       owed_results[$];

    function automatic id_result_t result_of(input logic [ID_W-1:0] id,
                                             input logic [STAT_W-1:0] st,
                                             input logic last);
        id_result_t r;
        r.ident      = id;
        r.status     = st;
        r.free_total = free_num;
        r.last       = last;
        return r;
    endfunction

    // every 6-bit ident lies inside a 64-entry pool, so no range test is needed
    task automatic apply_command(input logic [15:0] word);
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] want;
        int               lowest;
        int               top_live;
        int               i;
        cmd      = word[2:0];
        id       = word[8:3];
        want     = word[15:9];
        lowest   = -1;
        top_live = -1;
        for (i = MAP_W - 1; i >= 0; i--) begin
            if (free_bits[i])
                lowest = i;
            else if (top_live < 0)
                top_live = i;
        end
        case (cmd)
            CMD_ALLOC: begin
                if (lowest < 0) begin
                    owed_results.push_back(result_of('0, STAT_FULL, 1'b1));
                end else begin
                    free_bits[lowest] = 1'b0;
                    free_num          = free_num - CNT_W'(1);
                    owed_results.push_back(result_of(lowest[ID_W-1:0], STAT_OK, 1'b1));
                end
            end
            CMD_CLAIM: begin
                if (!free_bits[id]) begin
                    owed_results.push_back(result_of('0, STAT_LIVE, 1'b1));
                end else begin
                    free_bits[id] = 1'b0;
                    free_num      = free_num - CNT_W'(1);
                    owed_results.push_back(result_of('0, STAT_OK, 1'b1));
                end
            end
            CMD_RELEASE: begin
                if (free_bits[id]) begin
                    owed_results.push_back(result_of('0, STAT_FREE, 1'b1));
                end else begin
                    free_bits[id] = 1'b1;
                    free_num      = free_num + CNT_W'(1);
                    owed_results.push_back(result_of('0, STAT_OK, 1'b1));
                end
            end
            CMD_LIST: begin
                if (top_live < 0) begin
                    owed_results.push_back(result_of('0, STAT_SHORT, 1'b1));
                end else begin
                    for (i = 0; i <= top_live; i++)
                        if (!free_bits[i])
                            owed_results.push_back(result_of(i[ID_W-1:0], STAT_OK,
                                                              i == top_live));
                end
            end
            CMD_RESERVE: begin
                owed_results.push_back(result_of('0, (free_num >= want) ? STAT_OK : STAT_SHORT,
                                                  1'b1));
            end
            default: begin
                owed_results.push_back(result_of('0, STAT_OK, 1'b1));
            end
        endcase
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
        free_bits  = '1;
        free_num   = CNT_W'(MAP_W);
    end

    always @(posedge aclk) begin : watch
        id_result_t seen;
        id_result_t owed;
        if (!aresetn) begin
            free_bits = '1;
            free_num  = CNT_W'(MAP_W);
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_command(s_tdata);
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[5:0], m_tdata[8:6], m_tdata[15:9], m_tlast};
                if (owed_results.size() == 0) begin
                    $display("%0t: expected no item, got ident %0d status %0d free %0d last %0d",
                             $time, seen.ident, seen.status, seen.free_total, seen.last);
                    fail_count++;
                end else begin
                    owed = owed_results.pop_front();
                    if (seen != owed) begin
                        fail_count++;
                        if (seen.ident != owed.ident)
                            $display("%0t: result_ident expected %0d, got %0d",
                                     $time, owed.ident, seen.ident);
                        if (seen.status != owed.status)
                            $display("%0t: status expected %0d, got %0d",
                                     $time, owed.status, seen.status);
                        if (seen.free_total != owed.free_total)
                            $display("%0t: free_total expected %0d, got %0d",
                                     $time, owed.free_total, seen.free_total);
                        if (seen.last != owed.last)
                            $display("%0t: last expected %0d, got %0d",
                                     $time, owed.last, seen.last);
                    end
                end
            end
        end
        pending = owed_results.size();
    end

endmodule

### bench/bitmap_id_allocator_top_test.sv
`timescale 1ns / 1ps
// testbench top for the bitmap id allocator: clock, reset, command stimulus, verdict
// depends on bia_pkg, bitmap_id_allocator_top and bia_result_checker

module bitmap_id_allocator_top_test;
    import bia_pkg::*;

    // worst case: every item a full list of 64, each result stalled by the longest burst
    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 390;
    // no idling on either side for the last stretch of items
    localparam int QUIET_TAIL   = 50;

    // command mix of one random episode
    typedef enum logic [1:0] {
        FILL_UP,
        DRAIN_DOWN,
        MIXED
    } mix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // cmd[2:0], ident[8:3], want_count[15:9]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;         // result_ident[5:0], status[8:6], free_total[15:9]
    logic        m_tlast;

    int fail_count;
    int pending;
    int cycles    = 0;
    // percent chance of an idle burst before an item / on the result side
    int send_odds = 0;
    int recv_odds = 0;

    always #5 aclk = ~aclk;

    bitmap_id_allocator_top #(
        .CAPACITY (64)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bia_result_checker result_watch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // run-away guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure: stall bursts drawn at the recv_odds percent chance
    initial begin
        forever begin
            @(negedge aclk);
            if (recv_odds != 0 && $urandom_range(99) < recv_odds) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    // tvalid stays high between back-to-back items, so it is written once per step
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                            input logic [CNT_W-1:0] want);
        int gap;
        gap = (send_odds != 0 && $urandom_range(99) < send_odds) ? $urandom_range(7, 1) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {want, id, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // sender holds off until every predicted result has come back
    task automatic hold_until_settled();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    // weighted command choice, cumulative percent thresholds per mix
    function automatic logic [CMD_W-1:0] pick_cmd(input mix_t mode);
        int               roll;
        int               t_alloc;
        int               t_claim;
        int               t_release;
        int               t_list;
        int               t_reserve;
        logic [CMD_W-1:0] spare;
        roll  = $urandom_range(99);
        spare = CMD_W'($urandom_range(3, 1));
        case (mode)
            FILL_UP: begin
                t_alloc = 60; t_claim = 80; t_release = 83; t_list = 90; t_reserve = 97;
            end
            DRAIN_DOWN: begin
                t_alloc = 8; t_claim = 15; t_release = 80; t_list = 88; t_reserve = 96;
            end
            default: begin
                t_alloc = 28; t_claim = 46; t_release = 74; t_list = 84; t_reserve = 94;
            end
        endcase
        if (roll < t_alloc)
            return CMD_ALLOC;
        else if (roll < t_claim)
            return CMD_CLAIM;
        else if (roll < t_release)
            return CMD_RELEASE;
        else if (roll < t_list)
            return CMD_LIST;
        else if (roll < t_reserve)
            return CMD_RESERVE;
        else
            return CMD_RESERVE + spare;   // codes past reserve are unused
    endfunction

    initial begin : stimulus
        mix_t             mode;
        int               sent;
        int               span;
        logic [CNT_W-1:0] want;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reserve at and past the capacity, empty pool corners
        send_cmd(CMD_RESERVE, 6'd0, 7'd64);      // exactly enough free
        send_cmd(CMD_RESERVE, 6'd0, 7'd65);      // more than capacity
        send_cmd(CMD_RESERVE, 6'd0, 7'd127);
        send_cmd(CMD_RESERVE, 6'd0, 7'd0);
        send_cmd(CMD_LIST, 6'd0, 7'd0);          // nothing live
        send_cmd(CMD_RELEASE, 6'd0, 7'd0);       // already free, lowest id
        send_cmd(CMD_RELEASE, 6'd63, 7'd0);      // already free, highest id
        send_cmd(CMD_CLAIM, 6'd63, 7'd0);
        send_cmd(CMD_CLAIM, 6'd63, 7'd0);        // already live
        send_cmd(CMD_CLAIM, 6'd0, 7'd0);
        send_cmd(CMD_ALLOC, 6'd0, 7'd0);         // lowest free skips claimed id 0
        send_cmd(CMD_ALLOC, 6'd0, 7'd0);
        send_cmd(CMD_LIST, 6'd0, 7'd0);          // several live, highest marked last
        hold_until_settled();
        send_cmd(CMD_RELEASE, 6'd1, 7'd0);
        send_cmd(CMD_ALLOC, 6'd0, 7'd0);         // hole is reused first
        send_cmd(CMD_RESERVE, 6'd0, 7'd60);      // free count just enough
        send_cmd(CMD_RESERVE, 6'd0, 7'd61);      // one short
        send_cmd(CMD_RESERVE + 3'd1, 6'h3f, 7'h7f);
        send_cmd(CMD_RESERVE + 3'd2, 6'h2a, 7'h55);
        send_cmd(CMD_RESERVE + 3'd3, 6'h15, 7'h2a);
        send_cmd(CMD_RELEASE, 6'd0, 7'd0);
        send_cmd(CMD_RELEASE, 6'd1, 7'd0);
        send_cmd(CMD_RELEASE, 6'd2, 7'd0);
        send_cmd(CMD_RELEASE, 6'd63, 7'd0);
        send_cmd(CMD_LIST, 6'd0, 7'd0);          // empty again

        // random episodes, the first one long and fill-heavy so the pool runs full
        sent = 0;
        mode = FILL_UP;
        while (sent < RANDOM_ITEMS) begin
            span      = (sent == 0) ? 110 : $urandom_range(60, 25);
            send_odds = 10 * $urandom_range(4);
            recv_odds = 10 * $urandom_range(4);
            repeat (span) begin
                if (sent < RANDOM_ITEMS) begin
                    if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                        send_odds = 0;
                        recv_odds = 0;
                    end
                    want = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(127))
                                                    : CNT_W'($urandom_range(70));
                    send_cmd(pick_cmd(mode), ID_W'($urandom_range(63)), want);
                    sent++;
                end
            end
            mode = mix_t'($urandom_range(2));
            if ($urandom_range(3) == 0)
                hold_until_settled();
        end

        // drain and let any stray item surface
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bia_pkg.sv
rtl/core/bia_front.sv
rtl/core/bia_back.sv
rtl/core/bitmap_id_allocator_top.sv
rtl/core/bia_checker.sv
bench/bia_result_checker.sv
bench/bitmap_id_allocator_top_test.sv
